// File: rtl/core/clmh_pkg.sv
package clmh_pkg;

	localparam int MAX_ITEMS     = 1024;
	localparam int MAX_SYMBOLS   = 20;
	localparam int FIELD_SYMBOLS = 20;
	localparam int SYM_LIMIT     = (MAX_SYMBOLS < FIELD_SYMBOLS) ? MAX_SYMBOLS : FIELD_SYMBOLS;
	localparam int ADDR_W        = $clog2(MAX_ITEMS);
	localparam int KEY_W         = 2 * FIELD_SYMBOLS;
	localparam int CNT_W         = 11;
	localparam int SYM_W         = 5;
	localparam int TOT_W         = $clog2(MAX_ITEMS + 1);
	localparam int ENTRY_W       = 1 + KEY_W + CNT_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [SYM_W-1:0] SYM_RESET = SYM_W'(20);

	// keep the leading n symbols, n saturated to the field limit
	function automatic logic [KEY_W-1:0] cut_key(input logic [KEY_W-1:0] seq,
			input logic [SYM_W-1:0] n);
		logic [KEY_W-1:0] k;
		logic [SYM_W:0]   lim;
		lim = ({1'b0, n} > (SYM_W+1)'(SYM_LIMIT)) ? (SYM_W+1)'(SYM_LIMIT) : {1'b0, n};
		k = '0;
		for (int j = 0; j < FIELD_SYMBOLS; j++) begin
			if ((SYM_W+1)'(j) < lim) begin
				k[2*j +: 2] = seq[2*j +: 2];
			end
		end
		return k;
	endfunction

	// xor fold of the key onto the table address
	function automatic logic [ADDR_W-1:0] hash_key(input logic [KEY_W-1:0] k);
		logic [ADDR_W-1:0] h;
		h = '0;
		for (int i = 0; i < KEY_W; i++) begin
			h[i % ADDR_W] = h[i % ADDR_W] ^ k[i];
		end
		return h;
	endfunction

endpackage

// File: rtl/core/clmh_ram.sv
module clmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/clone_multiplicity_histogram_core.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | opcode, sequence_req, bin_index
// out     | output    | out_valid/out_stall| value, rejected
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (symbols_used)
//
// one word at a time; a new key runs check, bin increment, final; a repeated key
// check, bin decrement, bin increment, final (check per linear probe); a bin read
// read, final; an insert when full or unused opcode: final; clear sweeps both memories,
// one entry per cycle; after reset the same sweep runs with in_stall high, no word out
// a result waits in the output register while the next word is accepted;
// a new result holds in the final state while one waits and out_stall is high
module clone_multiplicity_histogram_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [clmh_pkg::KEY_W-1:0]        sequence_req,
	input  logic [clmh_pkg::ADDR_W-1:0]       bin_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [clmh_pkg::CNT_W-1:0]        value,
	output logic                              rejected,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clmh_pkg::SYM_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_CHECK, ST_BDEC, ST_BINC, ST_RDB, ST_FIN
	} state_t;

	state_t                          state_q;
	logic [clmh_pkg::SYM_W-1:0]      symbols_q;
	logic [clmh_pkg::ADDR_W-1:0]     clr_addr_q;
	logic                            clr_reply_q;
	logic [clmh_pkg::ADDR_W-1:0]     probe_addr_q;
	logic [clmh_pkg::KEY_W-1:0]      key_q;
	logic [clmh_pkg::CNT_W-1:0]      cnt_q;
	logic [clmh_pkg::TOT_W-1:0]      total_q;
	logic [clmh_pkg::CNT_W-1:0]      res_value_q;
	logic                            res_rej_q;
	logic                            out_valid_q;
	logic [clmh_pkg::CNT_W-1:0]      value_q;
	logic                            rejected_q;

	// key table: {valid, key, count}
	logic                            k_we;
	logic [clmh_pkg::ADDR_W-1:0]     k_waddr, k_raddr;
	logic [clmh_pkg::ENTRY_W-1:0]    k_wdata, k_rdata;
	// histogram bins
	logic                            b_we;
	logic [clmh_pkg::ADDR_W-1:0]     b_waddr, b_raddr;
	logic [clmh_pkg::CNT_W-1:0]      b_wdata, b_rdata;

	logic                            accept;
	logic [clmh_pkg::KEY_W-1:0]      in_key;
	logic                            e_valid;
	logic [clmh_pkg::KEY_W-1:0]      e_key;
	logic [clmh_pkg::CNT_W-1:0]      e_cnt;
	logic                            hit, empty;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign rejected  = rejected_q;

	assign in_key = clmh_pkg::cut_key(sequence_req, symbols_q);
	assign {e_valid, e_key, e_cnt} = k_rdata;
	assign hit   = (state_q == ST_CHECK) && e_valid && (e_key == key_q);
	assign empty = (state_q == ST_CHECK) && !e_valid;

	clmh_ram #(.WIDTH(clmh_pkg::ENTRY_W), .DEPTH(clmh_pkg::MAX_ITEMS)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	clmh_ram #(.WIDTH(clmh_pkg::CNT_W), .DEPTH(clmh_pkg::MAX_ITEMS)) u_bins (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	// memory control
	always_comb begin
		k_we    = 1'b0;
		k_waddr = probe_addr_q;
		k_wdata = '0;
		k_raddr = probe_addr_q;
		b_we    = 1'b0;
		b_waddr = cnt_q[clmh_pkg::ADDR_W-1:0];
		b_wdata = '0;
		b_raddr = '0;
		unique case (state_q)
			ST_CLR: begin
				k_we    = 1'b1;
				k_waddr = clr_addr_q;
				b_we    = 1'b1;
				b_waddr = clr_addr_q;
			end
			ST_IDLE: begin
				// start the first probe and any bin read straight away
				k_raddr = clmh_pkg::hash_key(in_key);
				b_raddr = bin_index;
			end
			ST_CHECK: begin
				k_raddr = probe_addr_q + 1'b1;
				if (hit) begin
					k_we    = 1'b1;
					k_wdata = {1'b1, key_q, e_cnt + 1'b1};
					b_raddr = clmh_pkg::ADDR_W'(e_cnt - 1'b1);
				end else if (empty) begin
					k_we    = 1'b1;
					k_wdata = {1'b1, key_q, clmh_pkg::CNT_W'(1)};
				end
			end
			ST_BDEC: begin
				// old bin loses a group, next bin read behind it
				b_we    = 1'b1;
				b_waddr = clmh_pkg::ADDR_W'(cnt_q - 1'b1);
				b_wdata = b_rdata - 1'b1;
				b_raddr = cnt_q[clmh_pkg::ADDR_W-1:0];
			end
			ST_BINC: begin
				b_we    = 1'b1;
				b_waddr = probe_addr_q;
				b_wdata = b_rdata + 1'b1;
			end
			ST_RDB, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			symbols_q   <= clmh_pkg::SYM_RESET;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			probe_addr_q <= '0;
			key_q       <= '0;
			cnt_q       <= '0;
			res_value_q <= '0;
			res_rej_q   <= 1'b0;
			value_q     <= '0;
			rejected_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				symbols_q <= cfg_data;
			end
			// the final state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					total_q    <= '0;
					if (clr_addr_q == clmh_pkg::ADDR_W'(clmh_pkg::MAX_ITEMS - 1)) begin
						state_q <= clr_reply_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_value_q <= '0;
						res_rej_q   <= 1'b0;
						case (opcode)
							clmh_pkg::OP_INSERT: begin
								if (total_q >= clmh_pkg::TOT_W'(clmh_pkg::MAX_ITEMS)) begin
									res_rej_q <= 1'b1;
									state_q   <= ST_FIN;
								end else begin
									key_q        <= in_key;
									probe_addr_q <= clmh_pkg::hash_key(in_key);
									state_q      <= ST_CHECK;
								end
							end
							clmh_pkg::OP_READ: state_q <= ST_RDB;
							clmh_pkg::OP_CLEAR: begin
								clr_addr_q  <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CHECK: begin
					if (hit) begin
						cnt_q   <= e_cnt;
						total_q <= total_q + 1'b1;
						state_q <= ST_BDEC;
					end else if (empty) begin
						total_q      <= total_q + 1'b1;
						res_value_q  <= clmh_pkg::CNT_W'(1);
						probe_addr_q <= '0;
						state_q      <= ST_BINC;
					end else begin
						probe_addr_q <= probe_addr_q + 1'b1;
					end
				end
				ST_BDEC: begin
					probe_addr_q <= cnt_q[clmh_pkg::ADDR_W-1:0];
					res_value_q  <= cnt_q + 1'b1;
					state_q      <= ST_BINC;
				end
				ST_BINC: state_q <= ST_FIN;
				ST_RDB: begin
					res_value_q <= b_rdata;
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						value_q     <= res_value_q;
						rejected_q  <= res_rej_q;
						clr_reply_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= clmh_pkg::TOT_W'(clmh_pkg::MAX_ITEMS))
		else $error("item total above capacity");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rejected_q |-> value_q == '0)
		else $error("rejected insert with nonzero value");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("word taken while idle after accept");
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && out_stall |=> state_q == ST_FIN)
		else $error("result dropped while output stalled");
`endif

endmodule
